// File: rtl/rcfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfc_pkg
// types and constants shared by the colour frequency classifier
// ----------------------------------------------------------------------------
package rcfc_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int TICK_WIDTH_DEF  = 24;

    localparam int REG_WIDTH       = 24;
    localparam int OUT_COUNT_WIDTH = 24;
    localparam int CFG_IDX_WIDTH   = 2;

    localparam logic [REG_WIDTH-1:0] SETTLE_RESET = 24'd35000;
    localparam logic [REG_WIDTH-1:0] GATE_RESET   = 24'd50100;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SETTLE = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_GATE   = 2'd1;

    localparam logic [1:0] COL_NONE  = 2'd0;
    localparam logic [1:0] COL_RED   = 2'd1;
    localparam logic [1:0] COL_GREEN = 2'd2;
    localparam logic [1:0] COL_BLUE  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SETTLE = 2'd1,
        PH_GATE   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        STEP_RED   = 2'd0,
        STEP_GREEN = 2'd1,
        STEP_BLUE  = 2'd2
    } t_step;

    typedef struct packed {
        logic                       select_s2;
        logic                       select_s3;
        logic                       busy_res;
        logic                       done_res;
        logic [1:0]                 colour;
        logic [OUT_COUNT_WIDTH-1:0] red_count;
        logic [OUT_COUNT_WIDTH-1:0] green_count;
        logic [OUT_COUNT_WIDTH-1:0] blue_count;
    } t_result;

endpackage
`default_nettype wire

// File: rtl/rcfc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcfc channel interfaces
// sample input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface rcfc_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic sensor_level;

    modport source (output valid, output start_req, output sensor_level, input ready);
    modport sink   (input valid, input start_req, input sensor_level, output ready);
endinterface

interface rcfc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 select_s2;
    logic                                 select_s3;
    logic                                 busy_res;
    logic                                 done_res;
    logic [1:0]                           colour;
    logic [rcfc_pkg::OUT_COUNT_WIDTH-1:0] red_count;
    logic [rcfc_pkg::OUT_COUNT_WIDTH-1:0] green_count;
    logic [rcfc_pkg::OUT_COUNT_WIDTH-1:0] blue_count;

    modport source (output valid, output select_s2, output select_s3, output busy_res,
                    output done_res, output colour, output red_count, output green_count,
                    output blue_count, input ready);
    modport sink   (input valid, input select_s2, input select_s3, input busy_res,
                    input done_res, input colour, input red_count, input green_count,
                    input blue_count, output ready);
endinterface

interface rcfc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rcfc_pkg::CFG_IDX_WIDTH-1:0] index;
    logic [rcfc_pkg::REG_WIDTH-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rgb_colour_frequency_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_colour_frequency_classifier_unit
// gated rising-edge counter over red, green and blue filters, reports the
// three counts and the strongest colour
// ----------------------------------------------------------------------------
//  channel    dir  word                                  accepted when
//  i_in_ch    in   start_req, sensor_level               valid && ready
//  o_out_ch   out  select lines, busy, done, colour,     valid && ready
//                  red/green/blue counts
//  i_cfg_ch   in   index, data (settle, gate ticks)      valid && ready
//
//  one sample word per cycle while input ready is high; its result word is
//  registered in the output register, or in the skid register when stalled
//  a skid register holds a second result while the output stalls; input
//  ready drops only while the skid register is full
//  reset clears phase, counters, stored counts and both result slots
//  config ready is always high
// ----------------------------------------------------------------------------
module rgb_colour_frequency_classifier_unit #(
    parameter int COUNT_WIDTH = rcfc_pkg::COUNT_WIDTH_DEF,
    parameter int TICK_WIDTH  = rcfc_pkg::TICK_WIDTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    rcfc_in_if.sink      i_in_ch,
    rcfc_out_if.source   o_out_ch,
    rcfc_cfg_if.sink     i_cfg_ch
);

    localparam int LIM_WIDTH = 33;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [TICK_WIDTH-1:0]  TICK_MAX  = '1;
    localparam logic [LIM_WIDTH-1:0]   TICK_MAX_EXT = LIM_WIDTH'(TICK_MAX);

    logic [rcfc_pkg::REG_WIDTH-1:0] r_settle;
    logic [rcfc_pkg::REG_WIDTH-1:0] r_gate;

    rcfc_pkg::t_phase r_phase, n_phase;
    rcfc_pkg::t_step  r_step, n_step;
    logic [TICK_WIDTH-1:0]  r_tick, n_tick;
    logic [COUNT_WIDTH-1:0] r_edge, n_edge;
    logic                   r_prev;
    logic [COUNT_WIDTH-1:0] r_counts [3];
    logic [COUNT_WIDTH-1:0] n_counts [3];
    logic [1:0]             r_colour, n_colour;
    logic                   n_done;

    rcfc_pkg::t_result r_out, r_skid, n_res;
    logic r_out_valid, r_skid_valid;

    logic in_fire, out_fire;
    logic [LIM_WIDTH-1:0] settle_ext, gate_ext, settle_lim, gate_lim;
    logic [TICK_WIDTH-1:0]  tick_inc;
    logic [COUNT_WIDTH-1:0] edge_inc;
    logic settle_end, gate_end, rise;
    logic [63:0] cnt0_ext, cnt1_ext, cnt2_ext;

    assign in_fire  = i_in_ch.valid && i_in_ch.ready;
    assign out_fire = r_out_valid && o_out_ch.ready;
    assign i_in_ch.ready = !r_skid_valid;
    assign i_cfg_ch.ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= rcfc_pkg::SETTLE_RESET;
            r_gate   <= rcfc_pkg::GATE_RESET;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                rcfc_pkg::CFG_SETTLE: r_settle <= i_cfg_ch.data;
                rcfc_pkg::CFG_GATE:   r_gate   <= i_cfg_ch.data;
                default: ;
            endcase
        end
    end

    // limits clamped to tick counter full scale
    assign settle_ext = LIM_WIDTH'(r_settle);
    assign gate_ext   = LIM_WIDTH'(r_gate);
    assign settle_lim = (settle_ext > TICK_MAX_EXT) ? TICK_MAX_EXT : settle_ext;
    assign gate_lim   = (gate_ext > TICK_MAX_EXT) ? TICK_MAX_EXT : gate_ext;

    assign tick_inc = (r_tick != TICK_MAX) ? r_tick + 1'b1 : r_tick;
    assign rise     = i_in_ch.sensor_level && !r_prev;
    assign edge_inc = (rise && r_edge != COUNT_MAX) ? r_edge + 1'b1 : r_edge;

    assign settle_end = LIM_WIDTH'(tick_inc) >= settle_lim;
    assign gate_end   = (LIM_WIDTH'(tick_inc) >= gate_lim) || (gate_lim == '0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            rcfc_pkg::PH_IDLE: begin
                if (i_in_ch.start_req) begin
                    n_phase = (r_settle == '0) ? rcfc_pkg::PH_GATE : rcfc_pkg::PH_SETTLE;
                end
            end
            rcfc_pkg::PH_SETTLE: begin
                if (settle_end) begin
                    n_phase = rcfc_pkg::PH_GATE;
                end
            end
            rcfc_pkg::PH_GATE: begin
                if (gate_end) begin
                    if (r_step == rcfc_pkg::STEP_BLUE) begin
                        n_phase = rcfc_pkg::PH_IDLE;
                    end else begin
                        n_phase = (r_settle == '0) ? rcfc_pkg::PH_GATE
                                                   : rcfc_pkg::PH_SETTLE;
                    end
                end
            end
            default: n_phase = rcfc_pkg::PH_IDLE;
        endcase
    end

    // counters, stored counts and colour decision
    always_comb begin
        n_step      = r_step;
        n_tick      = r_tick;
        n_edge      = r_edge;
        n_counts[0] = r_counts[0];
        n_counts[1] = r_counts[1];
        n_counts[2] = r_counts[2];
        n_colour    = r_colour;
        n_done      = 1'b0;
        unique case (r_phase)
            rcfc_pkg::PH_IDLE: begin
                if (i_in_ch.start_req) begin
                    n_counts[0] = '0;
                    n_counts[1] = '0;
                    n_counts[2] = '0;
                    n_colour    = rcfc_pkg::COL_NONE;
                    n_step      = rcfc_pkg::STEP_RED;
                    n_tick      = '0;
                    n_edge      = '0;
                end
            end
            rcfc_pkg::PH_SETTLE: begin
                n_tick = settle_end ? '0 : tick_inc;
            end
            rcfc_pkg::PH_GATE: begin
                n_tick = tick_inc;
                n_edge = edge_inc;
                if (gate_end) begin
                    n_tick = '0;
                    n_edge = '0;
                    unique case (r_step)
                        rcfc_pkg::STEP_RED: begin
                            n_counts[0] = edge_inc;
                            n_step      = rcfc_pkg::STEP_GREEN;
                        end
                        rcfc_pkg::STEP_GREEN: begin
                            n_counts[1] = edge_inc;
                            n_step      = rcfc_pkg::STEP_BLUE;
                        end
                        default: begin
                            n_counts[2] = edge_inc;
                            n_step      = rcfc_pkg::STEP_RED;
                            n_done      = 1'b1;
                            if (r_counts[0] < r_counts[1]) begin
                                n_colour = (r_counts[1] < edge_inc) ? rcfc_pkg::COL_BLUE
                                                                    : rcfc_pkg::COL_GREEN;
                            end else begin
                                n_colour = (r_counts[0] < edge_inc) ? rcfc_pkg::COL_BLUE
                                                                    : rcfc_pkg::COL_RED;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // result word
    assign cnt0_ext = 64'(n_counts[0]);
    assign cnt1_ext = 64'(n_counts[1]);
    assign cnt2_ext = 64'(n_counts[2]);

    always_comb begin
        n_res.select_s2   = (n_step == rcfc_pkg::STEP_GREEN);
        n_res.select_s3   = (n_step == rcfc_pkg::STEP_GREEN) ||
                            (n_step == rcfc_pkg::STEP_BLUE);
        n_res.busy_res    = (n_phase != rcfc_pkg::PH_IDLE);
        n_res.done_res    = n_done;
        n_res.colour      = n_colour;
        n_res.red_count   = cnt0_ext[rcfc_pkg::OUT_COUNT_WIDTH-1:0];
        n_res.green_count = cnt1_ext[rcfc_pkg::OUT_COUNT_WIDTH-1:0];
        n_res.blue_count  = cnt2_ext[rcfc_pkg::OUT_COUNT_WIDTH-1:0];
    end

    // measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rcfc_pkg::PH_IDLE;
            r_step      <= rcfc_pkg::STEP_RED;
            r_tick      <= '0;
            r_edge      <= '0;
            r_prev      <= 1'b0;
            r_counts[0] <= '0;
            r_counts[1] <= '0;
            r_counts[2] <= '0;
            r_colour    <= rcfc_pkg::COL_NONE;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_tick      <= n_tick;
            r_edge      <= n_edge;
            r_prev      <= i_in_ch.sensor_level;
            r_counts[0] <= n_counts[0];
            r_counts[1] <= n_counts[1];
            r_counts[2] <= n_counts[2];
            r_colour    <= n_colour;
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (r_out_valid && !out_fire && in_fire) begin
            r_skid <= n_res;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.select_s2   = r_out.select_s2;
    assign o_out_ch.select_s3   = r_out.select_s3;
    assign o_out_ch.busy_res    = r_out.busy_res;
    assign o_out_ch.done_res    = r_out.done_res;
    assign o_out_ch.colour      = r_out.colour;
    assign o_out_ch.red_count   = r_out.red_count;
    assign o_out_ch.green_count = r_out.green_count;
    assign o_out_ch.blue_count  = r_out.blue_count;

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done word still reports busy");

    a_idle_is_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == rcfc_pkg::PH_IDLE) |-> (r_step == rcfc_pkg::STEP_RED))
        else $error("idle with a filter other than red");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_ch.start_req && r_phase == rcfc_pkg::PH_IDLE)
        |=> (r_phase != rcfc_pkg::PH_IDLE))
        else $error("start word did not begin a measurement");

endmodule
`default_nettype wire
